// File: hw/rtl/point_rotate_project_unit_defines.svh
// Assertion macros shared by the point rotate/project RTL.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef POINT_ROTATE_PROJECT_UNIT_DEFINES_SVH
`define POINT_ROTATE_PROJECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/prp_pkg.sv
// Shared constants, register codes and sine table generator for the point
// rotate/project pipeline. No dependencies.
`default_nettype none

package prp_pkg;

  localparam int ANGLE_BITS_DEF     = 10;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int COORD_BITS_DEF     = 24;

  // Field and register widths
  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 16;
  localparam int ZOOM_W     = 8;
  localparam int HSCALE_W   = 8;
  localparam int CENTER_W   = 20;
  localparam int OFFSET_W   = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_TDATA_W = 40;

  // Internal datapath widths
  localparam int XY0_W = COL_W + ZOOM_W + 1;   // scaled x/y minus center
  localparam int Z0_W  = HGT_W + HSCALE_W;     // scaled height
  localparam int ROT_W = 26;                   // coordinates after each rotation
  localparam int ISO_W = 28;                   // after isometric projection
  localparam int FIN_W = ISO_W + 1;            // after screen offset

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM         = 3'd0,
    REG_HEIGHT_SCALE = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_ANGLES       = 3'd4,
    REG_ISO_MODE     = 3'd5,
    REG_SCREEN_X_OFF = 3'd6,
    REG_SCREEN_Y_OFF = 3'd7
  } cfg_reg_t;

  localparam longint unsigned Q30_ONE       = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30   = 64'd1686629713;
  localparam longint unsigned ISO_ANGLE_Q30 = 64'd562210145;

  // sin of a Q30 angle in [0, pi/2], Taylor form, rounded to frac_bits
  function automatic longint unsigned trig_q30(input longint unsigned x,
                                               input int frac_bits);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 6);
    s  = (x * t) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    s = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    return s;
  endfunction

  // Q30 angle of step r within a quadrant
  function automatic longint unsigned quarter_angle(input longint unsigned r,
                                                    input int angle_bits);
    return (r * HALF_PI_Q30) >> (angle_bits - 2);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/prp_scale.sv
// Entry stage: scales column/row/height, subtracts centers and looks up the
// sine/cosine pairs of the three rotation angles. Uses prp_pkg.
`default_nettype none

module prp_scale #(
  parameter int ANGLE_BITS     = prp_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = prp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [prp_pkg::COL_W-1:0]             map_col,
  input  logic [prp_pkg::ROW_W-1:0]             map_row,
  input  logic signed [prp_pkg::HGT_W-1:0]      map_height,
  input  logic [prp_pkg::ZOOM_W-1:0]            zoom,
  input  logic [prp_pkg::HSCALE_W-1:0]          height_scale,
  input  logic [prp_pkg::CENTER_W-1:0]          center_x,
  input  logic [prp_pkg::CENTER_W-1:0]          center_y,
  input  logic [3*ANGLE_BITS-1:0]               rotation_angles,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [prp_pkg::ROT_W-1:0]      x,
  output logic signed [prp_pkg::ROT_W-1:0]      y,
  output logic signed [prp_pkg::ROT_W-1:0]      z,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_z,
  output logic signed [TRIG_FRAC_BITS+1:0]      nsin_z,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_x,
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_x,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_y,
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_y
);
  import prp_pkg::*;

  localparam int QW      = ANGLE_BITS - 2;
  localparam int QUARTER = 1 << QW;
  localparam int TW      = TRIG_FRAC_BITS + 2;
  localparam int ROM_W   = TRIG_FRAC_BITS + 1;
  localparam logic [ROM_W-1:0] SIN_TOP =
    ROM_W'(trig_q30(quarter_angle(64'(QUARTER), ANGLE_BITS), TRIG_FRAC_BITS));

  // Quarter-wave sine table, built at elaboration
  logic [ROM_W-1:0] sin_rom [QUARTER];

  for (genvar g = 0; g < QUARTER; g++) begin : g_rom
    localparam longint unsigned ENTRY =
      trig_q30(quarter_angle(64'(g), ANGLE_BITS), TRIG_FRAC_BITS);
    assign sin_rom[g] = ROM_W'(ENTRY);
  end

  logic [ANGLE_BITS-1:0]   code  [3];
  logic [1:0]              quad  [3];
  logic [QW-1:0]           r     [3];
  logic [QW-1:0]           r_neg [3];
  logic signed [TW-1:0]    a_s   [3];
  logic signed [TW-1:0]    b_s   [3];
  logic signed [TW-1:0]    sn    [3];
  logic signed [TW-1:0]    cs    [3];
  logic signed [TW-1:0]    nsn_z;

  // Index 0 is the x angle, 1 the y angle, 2 the z angle
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      code[k]  = rotation_angles[k*ANGLE_BITS +: ANGLE_BITS];
      quad[k]  = code[k][ANGLE_BITS-1 -: 2];
      r[k]     = code[k][QW-1:0];
      r_neg[k] = QW'(0) - r[k];
      a_s[k]   = $signed({1'b0, sin_rom[r[k]]});
      b_s[k]   = (r[k] == '0) ? $signed({1'b0, SIN_TOP}) : $signed({1'b0, sin_rom[r_neg[k]]});
      unique case (quad[k])
        2'd0: begin sn[k] = a_s[k];  cs[k] = b_s[k];  end
        2'd1: begin sn[k] = b_s[k];  cs[k] = -a_s[k]; end
        2'd2: begin sn[k] = -a_s[k]; cs[k] = -b_s[k]; end
        2'd3: begin sn[k] = -b_s[k]; cs[k] = a_s[k];  end
      endcase
    end
    nsn_z = -sn[2];
  end

  logic [COL_W+ZOOM_W-1:0]   col_prod;
  logic [ROW_W+ZOOM_W-1:0]   row_prod;
  logic signed [XY0_W-1:0]   x_sc;
  logic signed [XY0_W-1:0]   y_sc;
  logic signed [Z0_W:0]      z_full;

  assign col_prod = (COL_W+ZOOM_W)'(map_col) * (COL_W+ZOOM_W)'(zoom);
  assign row_prod = (ROW_W+ZOOM_W)'(map_row) * (ROW_W+ZOOM_W)'(zoom);
  assign x_sc     = $signed({1'b0, col_prod}) - $signed({1'b0, center_x});
  assign y_sc     = $signed({1'b0, row_prod}) - $signed({1'b0, center_y});
  assign z_full   = (Z0_W+1)'(map_height) * (Z0_W+1)'($signed({1'b0, height_scale}));

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x      <= ROT_W'(x_sc);
      y      <= ROT_W'(y_sc);
      z      <= ROT_W'(z_full);
      cos_z  <= cs[2];
      nsin_z <= nsn_z;
      cos_x  <= cs[0];
      sin_x  <= sn[0];
      cos_y  <= cs[1];
      sin_y  <= sn[1];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/prp_rotate.sv
// Two-stage plane rotation: u' = trunc(u*c + v*s), v' = trunc(v*c - u*s),
// truncating toward zero. Carries a side payload alongside. Uses prp_pkg.
`default_nettype none

module prp_rotate #(
  parameter int TRIG_FRAC_BITS = prp_pkg::TRIG_FRAC_BITS_DEF,
  parameter int PASS_W         = prp_pkg::ROT_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [prp_pkg::ROT_W-1:0]  u,
  input  logic signed [prp_pkg::ROT_W-1:0]  v,
  input  logic signed [TRIG_FRAC_BITS+1:0]  c,
  input  logic signed [TRIG_FRAC_BITS+1:0]  s,
  input  logic [PASS_W-1:0]                 pass_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [prp_pkg::ROT_W-1:0]  u_out,
  output logic signed [prp_pkg::ROT_W-1:0]  v_out,
  output logic [PASS_W-1:0]                 pass_out
);
  import prp_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = ROT_W + TW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] BIAS = SW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

  logic                 va;
  logic                 rdy_a;
  logic                 rdy_b;
  logic signed [PW-1:0] p_uc;
  logic signed [PW-1:0] p_vs;
  logic signed [PW-1:0] p_vc;
  logic signed [PW-1:0] p_us;
  logic [PASS_W-1:0]    pass_a;

  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  // Stage A: four products
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      p_uc   <= PW'(u) * PW'(c);
      p_vs   <= PW'(v) * PW'(s);
      p_vc   <= PW'(v) * PW'(c);
      p_us   <= PW'(u) * PW'(s);
      pass_a <= pass_in;
    end
  end

  // Stage B: sums, truncate toward zero
  logic signed [SW-1:0] su;
  logic signed [SW-1:0] sv;
  logic signed [SW-1:0] su_adj;
  logic signed [SW-1:0] sv_adj;

  assign su     = SW'(p_uc) + SW'(p_vs);
  assign sv     = SW'(p_vc) - SW'(p_us);
  assign su_adj = su[SW-1] ? su + BIAS : su;
  assign sv_adj = sv[SW-1] ? sv + BIAS : sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_b) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      u_out    <= ROT_W'(su_adj >>> TRIG_FRAC_BITS);
      v_out    <= ROT_W'(sv_adj >>> TRIG_FRAC_BITS);
      pass_out <= pass_a;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/prp_finish.sv
// Tail of the pipeline: optional isometric projection, screen offsets and
// saturation into the output register. Uses prp_pkg and the assertion macros.
`default_nettype none
`include "point_rotate_project_unit_defines.svh"

module prp_finish #(
  parameter int TRIG_FRAC_BITS = prp_pkg::TRIG_FRAC_BITS_DEF,
  parameter int COORD_BITS     = prp_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [prp_pkg::ROT_W-1:0]    x,
  input  logic signed [prp_pkg::ROT_W-1:0]    y,
  input  logic signed [prp_pkg::ROT_W-1:0]    z,
  input  logic                                iso_mode,
  input  logic signed [prp_pkg::OFFSET_W-1:0] screen_x_offset,
  input  logic signed [prp_pkg::OFFSET_W-1:0] screen_y_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_BITS-1:0]        screen_x,
  output logic signed [COORD_BITS-1:0]        screen_y,
  output logic signed [COORD_BITS-1:0]        depth
);
  import prp_pkg::*;

  localparam int TW    = TRIG_FRAC_BITS + 2;
  localparam int MW    = ROT_W + 1 + TW;
  localparam int DW    = MW + 1;
  localparam int SAT_W = ((FIN_W > COORD_BITS) ? FIN_W : COORD_BITS) + 1;

  localparam logic signed [TW-1:0] ISO_C =
    TW'(trig_q30(HALF_PI_Q30 - ISO_ANGLE_Q30, TRIG_FRAC_BITS));
  localparam logic signed [TW-1:0] ISO_S = TW'(trig_q30(ISO_ANGLE_Q30, TRIG_FRAC_BITS));
  localparam logic signed [MW-1:0] BIAS_M = MW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);
  localparam logic signed [DW-1:0] BIAS_D = DW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);
  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [COORD_BITS-1:0] sat(input logic signed [SAT_W-1:0] val);
    logic [COORD_BITS-1:0] res;
    if (val > SAT_HI) res = SAT_HI[COORD_BITS-1:0];
    else if (val < SAT_LO) res = SAT_LO[COORD_BITS-1:0];
    else res = val[COORD_BITS-1:0];
    return res;
  endfunction

  logic va;
  logic vb;
  logic rdy_a;
  logic rdy_b;
  logic rdy_c;

  assign rdy_c     = !out_valid || out_ready;
  assign rdy_b     = !vb || rdy_c;
  assign rdy_a     = !va || rdy_b;
  assign in_ready  = rdy_a;

  // Stage A: projection products
  logic signed [ROT_W:0]    diff_xy;
  logic signed [ROT_W:0]    sum_xy;
  logic signed [MW-1:0]     pxm;
  logic signed [MW-1:0]     pym;
  logic signed [ROT_W-1:0]  x_a;
  logic signed [ROT_W-1:0]  y_a;
  logic signed [ROT_W-1:0]  z_a;

  assign diff_xy = (ROT_W+1)'(x) - (ROT_W+1)'(y);
  assign sum_xy  = (ROT_W+1)'(x) + (ROT_W+1)'(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      pxm <= MW'(diff_xy) * MW'(ISO_C);
      pym <= MW'(sum_xy) * MW'(ISO_S);
      x_a <= x;
      y_a <= y;
      z_a <= z;
    end
  end

  // Stage B: subtract depth term, truncate toward zero, pick view
  logic signed [DW-1:0]    zsh;
  logic signed [DW-1:0]    ym;
  logic signed [DW-1:0]    ym_adj;
  logic signed [MW-1:0]    xm_adj;
  logic signed [ISO_W-1:0] x_b;
  logic signed [ISO_W-1:0] y_b;
  logic signed [ROT_W-1:0] z_b;

  assign zsh    = DW'(z_a) <<< TRIG_FRAC_BITS;
  assign ym     = DW'(pym) - zsh;
  assign ym_adj = ym[DW-1] ? ym + BIAS_D : ym;
  assign xm_adj = pxm[MW-1] ? pxm + BIAS_M : pxm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      if (iso_mode) begin
        x_b <= ISO_W'(xm_adj >>> TRIG_FRAC_BITS);
        y_b <= ISO_W'(ym_adj >>> TRIG_FRAC_BITS);
      end else begin
        x_b <= ISO_W'(x_a);
        y_b <= ISO_W'(y_a);
      end
      z_b <= z_a;
    end
  end

  // Stage C: offsets and saturation into the output register
  logic signed [SAT_W-1:0] fx;
  logic signed [SAT_W-1:0] fy;
  logic signed [SAT_W-1:0] fz;

  assign fx = SAT_W'(x_b) + SAT_W'(screen_x_offset);
  assign fy = SAT_W'(y_b) + SAT_W'(screen_y_offset);
  assign fz = SAT_W'(z_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_c) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb) begin
      screen_x <= sat(fx);
      screen_y <= sat(fy);
      depth    <= sat(fz);
    end
  end

  `PRP_ASSERT_IMPLY(a_full_when_blocked, !in_ready, va && vb && out_valid, "stall with bubble")
  `PRP_ASSERT_NEXT(a_stage_b_drains, vb && out_ready, out_valid, "stage B item lost")
  `PRP_ASSERT_IMPLY(a_out_from_stage_b, $rose(out_valid), $past(vb), "output not from stage B")

endmodule

`default_nettype wire

// File: hw/rtl/point_rotate_project_unit.sv
// Point rotate/project unit: top level, configuration registers and stream ports.
// Stages in order: scale; rotations about z, x and y (products, then sums);
// projection (products, view); offset/saturate. One item per cycle unless stalled.
// Ready propagates back through the stages, so bubbles collapse under stall.
// Reset (rst, synchronous): clears all stage valid bits and loads register
// defaults (zoom 1, height scale 1, isometric on, others 0). Uses prp_pkg.
`default_nettype none

module point_rotate_project_unit #(
  parameter int ANGLE_BITS     = prp_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = prp_pkg::TRIG_FRAC_BITS_DEF,
  parameter int COORD_BITS     = prp_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // map_col [11:0], map_row [23:12], map_height [39:24]
  input  logic [prp_pkg::IN_TDATA_W-1:0]        s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // screen_x, screen_y, depth, COORD_BITS each from bit 0 up, zero padded
  output logic [((3*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  input  logic                                  cfg_we,
  input  logic [prp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [((3*ANGLE_BITS > prp_pkg::OFFSET_W) ?
                 3*ANGLE_BITS : prp_pkg::OFFSET_W)-1:0] cfg_data
);
  import prp_pkg::*;

  localparam int TW          = TRIG_FRAC_BITS + 2;
  localparam int OUT_TDATA_W = ((3*COORD_BITS+7)/8)*8;

  // Configuration registers
  logic [ZOOM_W-1:0]          zoom;
  logic [HSCALE_W-1:0]        height_scale;
  logic [CENTER_W-1:0]        center_x;
  logic [CENTER_W-1:0]        center_y;
  logic [3*ANGLE_BITS-1:0]    rotation_angles;
  logic                       iso_mode;
  logic signed [OFFSET_W-1:0] screen_x_offset;
  logic signed [OFFSET_W-1:0] screen_y_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom            <= ZOOM_W'(1);
      height_scale    <= HSCALE_W'(1);
      center_x        <= '0;
      center_y        <= '0;
      rotation_angles <= '0;
      iso_mode        <= 1'b1;
      screen_x_offset <= '0;
      screen_y_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZOOM:         zoom            <= cfg_data[ZOOM_W-1:0];
        REG_HEIGHT_SCALE: height_scale    <= cfg_data[HSCALE_W-1:0];
        REG_CENTER_X:     center_x        <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     center_y        <= cfg_data[CENTER_W-1:0];
        REG_ANGLES:       rotation_angles <= cfg_data[3*ANGLE_BITS-1:0];
        REG_ISO_MODE:     iso_mode        <= cfg_data[0];
        REG_SCREEN_X_OFF: screen_x_offset <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_SCREEN_Y_OFF: screen_y_offset <= $signed(cfg_data[OFFSET_W-1:0]);
      endcase
    end
  end

  // Scale stage
  logic                    sc_valid;
  logic                    sc_ready;
  logic signed [ROT_W-1:0] x0;
  logic signed [ROT_W-1:0] y0;
  logic signed [ROT_W-1:0] z0;
  logic signed [TW-1:0]    cos_z;
  logic signed [TW-1:0]    nsin_z;
  logic signed [TW-1:0]    cos_x;
  logic signed [TW-1:0]    sin_x;
  logic signed [TW-1:0]    cos_y;
  logic signed [TW-1:0]    sin_y;

  prp_scale #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_scale (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .map_col         (s_tdata[COL_W-1:0]),
    .map_row         (s_tdata[COL_W+ROW_W-1:COL_W]),
    .map_height      ($signed(s_tdata[COL_W+ROW_W+HGT_W-1:COL_W+ROW_W])),
    .zoom            (zoom),
    .height_scale    (height_scale),
    .center_x        (center_x),
    .center_y        (center_y),
    .rotation_angles (rotation_angles),
    .out_valid       (sc_valid),
    .out_ready       (sc_ready),
    .x               (x0),
    .y               (y0),
    .z               (z0),
    .cos_z           (cos_z),
    .nsin_z          (nsin_z),
    .cos_x           (cos_x),
    .sin_x           (sin_x),
    .cos_y           (cos_y),
    .sin_y           (sin_y)
  );

  // Rotation about z; z and the remaining trig pairs ride along
  localparam int RZ_PASS_W = ROT_W + 4*TW;

  logic                    rz_valid;
  logic                    rz_ready;
  logic signed [ROT_W-1:0] x1;
  logic signed [ROT_W-1:0] y1;
  logic [RZ_PASS_W-1:0]    rz_pass;

  prp_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .PASS_W         (RZ_PASS_W)
  ) u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .u         (x0),
    .v         (y0),
    .c         (cos_z),
    .s         (nsin_z),
    .pass_in   ({z0, cos_x, sin_x, cos_y, sin_y}),
    .out_valid (rz_valid),
    .out_ready (rz_ready),
    .u_out     (x1),
    .v_out     (y1),
    .pass_out  (rz_pass)
  );

  logic signed [ROT_W-1:0] z1;
  logic signed [TW-1:0]    cos_x1;
  logic signed [TW-1:0]    sin_x1;
  logic signed [TW-1:0]    cos_y1;
  logic signed [TW-1:0]    sin_y1;

  assign z1     = $signed(rz_pass[RZ_PASS_W-1 -: ROT_W]);
  assign cos_x1 = $signed(rz_pass[4*TW-1 -: TW]);
  assign sin_x1 = $signed(rz_pass[3*TW-1 -: TW]);
  assign cos_y1 = $signed(rz_pass[2*TW-1 -: TW]);
  assign sin_y1 = $signed(rz_pass[TW-1:0]);

  // Rotation about x: (y, z)
  localparam int RX_PASS_W = ROT_W + 2*TW;

  logic                    rx_valid;
  logic                    rx_ready;
  logic signed [ROT_W-1:0] y2;
  logic signed [ROT_W-1:0] z2;
  logic [RX_PASS_W-1:0]    rx_pass;

  prp_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .PASS_W         (RX_PASS_W)
  ) u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rz_valid),
    .in_ready  (rz_ready),
    .u         (y1),
    .v         (z1),
    .c         (cos_x1),
    .s         (sin_x1),
    .pass_in   ({x1, cos_y1, sin_y1}),
    .out_valid (rx_valid),
    .out_ready (rx_ready),
    .u_out     (y2),
    .v_out     (z2),
    .pass_out  (rx_pass)
  );

  logic signed [ROT_W-1:0] x2;
  logic signed [TW-1:0]    cos_y2;
  logic signed [TW-1:0]    sin_y2;

  assign x2     = $signed(rx_pass[RX_PASS_W-1 -: ROT_W]);
  assign cos_y2 = $signed(rx_pass[2*TW-1 -: TW]);
  assign sin_y2 = $signed(rx_pass[TW-1:0]);

  // Rotation about y: (x, z)
  logic                    ry_valid;
  logic                    ry_ready;
  logic signed [ROT_W-1:0] x3;
  logic signed [ROT_W-1:0] z3;
  logic [ROT_W-1:0]        ry_pass;

  prp_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .PASS_W         (ROT_W)
  ) u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx_valid),
    .in_ready  (rx_ready),
    .u         (x2),
    .v         (z2),
    .c         (cos_y2),
    .s         (sin_y2),
    .pass_in   (y2),
    .out_valid (ry_valid),
    .out_ready (ry_ready),
    .u_out     (x3),
    .v_out     (z3),
    .pass_out  (ry_pass)
  );

  // Projection, offsets, saturation
  logic signed [COORD_BITS-1:0] screen_x;
  logic signed [COORD_BITS-1:0] screen_y;
  logic signed [COORD_BITS-1:0] depth;

  prp_finish #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .COORD_BITS     (COORD_BITS)
  ) u_finish (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (ry_valid),
    .in_ready        (ry_ready),
    .x               (x3),
    .y               ($signed(ry_pass)),
    .z               (z3),
    .iso_mode        (iso_mode),
    .screen_x_offset (screen_x_offset),
    .screen_y_offset (screen_y_offset),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .screen_x        (screen_x),
    .screen_y        (screen_y),
    .depth           (depth)
  );

  assign m_tdata = OUT_TDATA_W'({depth, screen_y, screen_x});

endmodule

`default_nettype wire
